// ===== src/dwpi_pkg.sv =====
// shared types and constants for the dual wheel pi speed controller
package dwpi_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPD,
    ST_KI,
    ST_DT,
    ST_INC,
    ST_KP,
    ST_DUTY,
    ST_OUT
  } dwpi_state_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_VOLT_LIMIT  = 3'd2,
    REG_RIGHT_SGAIN = 3'd3,
    REG_LEFT_SGAIN  = 3'd4
  } dwpi_reg_t;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 52;
  localparam int DIV_D_W = 18;

  localparam logic [DIV_D_W-1:0] INC_DIVISOR  = 18'd250000;
  localparam logic [DIV_D_W-1:0] DUTY_DIVISOR = 18'd6656;

  localparam logic [15:0] PROP_GAIN_RST   = 16'd256;
  localparam logic [15:0] INTEG_GAIN_RST  = 16'd256;
  localparam logic [12:0] VOLT_LIMIT_RST  = 13'd6144;
  localparam logic [15:0] RIGHT_SGAIN_RST = 16'd8251;
  localparam logic [15:0] LEFT_SGAIN_RST  = 16'd9289;

endpackage

// ===== src/dwpi_smul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
module dwpi_smul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [dwpi_pkg::MUL_A_W-1:0]   a,
  input  logic [dwpi_pkg::MUL_B_W-1:0]   b,
  output logic                           done,
  output logic [dwpi_pkg::MUL_P_W-1:0]   prod
);
  import dwpi_pkg::*;

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [MUL_P_W-1:0] acc_r;
  logic [4:0]         cnt_r;
  logic               busy_r;
  logic               done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(MUL_B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[MUL_P_W-2:0], 1'b0} +
               (b_r[MUL_B_W-1] ? {{MUL_B_W{1'b0}}, a_r} : '0);
      b_r   <= {b_r[MUL_B_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== src/dwpi_sdiv.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module dwpi_sdiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dwpi_pkg::DIV_N_W-1:0] num,
  input  logic [dwpi_pkg::DIV_D_W-1:0] den,
  output logic                         done,
  output logic [dwpi_pkg::DIV_N_W-1:0] quo
);
  import dwpi_pkg::*;

  logic [DIV_N_W-1:0] num_r;
  logic [DIV_D_W-1:0] den_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [5:0]         cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_D_W:0]   trial;
  logic               fits;

  assign trial = {rem_r, num_r[DIV_N_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DIV_N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_N_W-2:0], fits};
      rem_r <= fits ? DIV_D_W'(trial - {1'b0, den_r}) : trial[DIV_D_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// ===== src/dual_wheel_pi_speed_controller.sv =====
// Dual wheel PI speed controller. The wheels are handled one after the other through one
// bit-serial 36x16 multiplier and one bit-serial restoring divider; each wheel needs four
// products and two quotients, with the duty divide launched from a register once the
// command is registered, and the tick ends by loading the output register and going back
// to idle. A new tick is taken once the previous one has gone to the output register, so
// the next tick may arrive while the last result still waits.
module dual_wheel_pi_speed_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_right_count,
  input  logic               in_right_dir,
  input  logic [15:0]        in_left_count,
  input  logic               in_left_dir,
  input  logic signed [18:0] in_right_target,
  input  logic signed [18:0] in_left_target,
  input  logic [15:0]        in_elapsed_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_right_duty,
  output logic signed [15:0] out_left_duty,
  output logic signed [18:0] out_right_speed,
  output logic signed [18:0] out_left_speed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import dwpi_pkg::*;

  dwpi_state_t state_r, state_nxt;

  logic [15:0] prop_gain_r, integ_gain_r, rsgain_r, lsgain_r;
  logic [12:0] vlimit_r;

  logic [15:0]        rcount_r, lcount_r, dt_r;
  logic               rneg_r, lneg_r;
  logic signed [18:0] rtarget_r, ltarget_r;
  logic               wheel_r;

  logic signed [18:0] rspeed_r, lspeed_r;
  logic signed [23:0] rinteg_r, linteg_r;
  logic signed [15:0] rduty_r, lduty_r;
  logic               err_neg_r;
  logic [18:0]        err_mag_r;
  logic               cmd_neg_r;
  logic [22:0]        cmd_mag_r;

  logic               out_valid_r;
  logic signed [15:0] out_rduty_r, out_lduty_r;
  logic signed [18:0] out_rspeed_r, out_lspeed_r;

  logic                 mul_start, mul_done, div_start, div_done;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_prod;
  logic [DIV_N_W-1:0]   div_num, div_quo;
  logic [DIV_D_W-1:0]   div_den;

  logic               in_acc, out_free;
  logic [15:0]        cur_count;
  logic [15:0]        cur_sgain;
  logic               cur_neg;
  logic signed [18:0] cur_target;
  logic signed [23:0] cur_integ;

  logic [32:0]        spd_rnd;
  logic [20:0]        spd_mag;
  logic signed [18:0] spd_val;
  logic signed [19:0] err_val;
  logic [19:0]        err_abs;

  logic signed [39:0] lim_pos, lim_neg;
  logic signed [39:0] inc_val, integ_sum;
  logic signed [23:0] integ_val;
  logic signed [39:0] pterm, cmd_sum, cmd_clamp;
  logic [39:0]        cmd_abs;
  logic [27:0]        duty_m;
  logic signed [15:0] duty_val;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign cur_count  = wheel_r ? lcount_r : rcount_r;
  assign cur_sgain  = wheel_r ? lsgain_r : rsgain_r;
  assign cur_neg    = wheel_r ? lneg_r : rneg_r;
  assign cur_target = wheel_r ? ltarget_r : rtarget_r;
  assign cur_integ  = wheel_r ? linteg_r : rinteg_r;

  // speed: half-up rounding from Q12.20 product, sign, saturate to Q10.8
  always_comb begin
    spd_rnd = {1'b0, mul_prod[31:0]} + 33'd2048;
    spd_mag = spd_rnd[32:12];
    if (cur_neg) begin
      if (spd_mag > 21'd262144) spd_val = -19'sd262144;
      else                      spd_val = -$signed(spd_mag[18:0]);
    end else begin
      if (spd_mag > 21'd262143) spd_val = 19'sd262143;
      else                      spd_val = $signed(spd_mag[18:0]);
    end
    err_val = 20'(cur_target) - 20'(spd_val);
    err_abs = err_val[19] ? 20'(-err_val) : err_val;
  end

  always_comb begin
    lim_pos   = $signed({17'd0, vlimit_r, 10'd0});
    lim_neg   = -lim_pos;
    inc_val   = err_neg_r ? -$signed({4'd0, div_quo[35:0]}) : $signed({4'd0, div_quo[35:0]});
    integ_sum = 40'(cur_integ) + inc_val;
    if (integ_sum > lim_pos)      integ_val = 24'(lim_pos);
    else if (integ_sum < lim_neg) integ_val = 24'(lim_neg);
    else                          integ_val = 24'(integ_sum);
    pterm   = err_neg_r ? -$signed({3'd0, mul_prod[34:0], 2'b00})
                        : $signed({3'd0, mul_prod[34:0], 2'b00});
    cmd_sum = pterm + 40'(cur_integ);
    if (cmd_sum > lim_pos)      cmd_clamp = lim_pos;
    else if (cmd_sum < lim_neg) cmd_clamp = lim_neg;
    else                        cmd_clamp = cmd_sum;
    cmd_abs  = cmd_clamp[39] ? 40'(-cmd_clamp) : cmd_clamp;
    // times 25 then plus half the divisor
    duty_m   = ({5'd0, cmd_mag_r} << 4) + ({5'd0, cmd_mag_r} << 3) + {5'd0, cmd_mag_r}
               + 28'd3328;
    duty_val = cmd_neg_r ? -$signed(div_quo[15:0]) : $signed(div_quo[15:0]);
  end

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = INC_DIVISOR;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(in_right_count);
          mul_b     = rsgain_r;
          state_nxt = ST_SPD;
        end
      end
      ST_SPD: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(err_abs);
          mul_b     = integ_gain_r;
          state_nxt = ST_KI;
        end
      end
      ST_KI: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod[MUL_A_W-1:0];
          mul_b     = dt_r;
          state_nxt = ST_DT;
        end
      end
      ST_DT: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_prod + DIV_N_W'(125000);
          div_den   = INC_DIVISOR;
          state_nxt = ST_INC;
        end
      end
      ST_INC: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(err_mag_r);
          mul_b     = prop_gain_r;
          state_nxt = ST_KP;
        end
      end
      ST_KP: begin
        if (mul_done) state_nxt = ST_DUTY;
      end
      ST_DUTY: begin
        // first cycle launches the divide, then wait for it
        if (div_done) begin
          if (!wheel_r) begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(lcount_r);
            mul_b     = lsgain_r;
            state_nxt = ST_SPD;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_KP && mul_done) begin
      div_start = 1'b0;
    end
  end

  // duty divide launches from duty_go_r, which is registered together with the command
  logic duty_go_r;
  logic div_start_all;
  assign div_start_all = div_start || duty_go_r;

  dwpi_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  dwpi_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_all),
    .num   (duty_go_r ? DIV_N_W'(duty_m) : div_num),
    .den   (duty_go_r ? DUTY_DIVISOR : div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wheel_r      <= 1'b0;
      duty_go_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      vlimit_r     <= VOLT_LIMIT_RST;
      rsgain_r     <= RIGHT_SGAIN_RST;
      lsgain_r     <= LEFT_SGAIN_RST;
      rinteg_r     <= '0;
      linteg_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      duty_go_r <= (state_r == ST_KP) && mul_done;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PROP_GAIN:   prop_gain_r  <= cfg_data;
          REG_INTEG_GAIN:  integ_gain_r <= cfg_data;
          REG_VOLT_LIMIT:  vlimit_r     <= cfg_data[12:0];
          REG_RIGHT_SGAIN: rsgain_r     <= cfg_data;
          REG_LEFT_SGAIN:  lsgain_r     <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) wheel_r <= 1'b0;
      else if (state_r == ST_DUTY && div_done) wheel_r <= 1'b1;
      if (state_r == ST_INC && div_done) begin
        if (wheel_r) linteg_r <= integ_val;
        else         rinteg_r <= integ_val;
      end
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rcount_r  <= in_right_count;
      lcount_r  <= in_left_count;
      rneg_r    <= in_right_dir;
      lneg_r    <= !in_left_dir;
      rtarget_r <= in_right_target;
      ltarget_r <= in_left_target;
      dt_r      <= in_elapsed_us;
    end
    if (state_r == ST_SPD && mul_done) begin
      err_neg_r <= err_val[19];
      err_mag_r <= err_abs[18:0];
      if (wheel_r) lspeed_r <= spd_val;
      else         rspeed_r <= spd_val;
    end
    if (state_r == ST_KP && mul_done) begin
      cmd_neg_r <= cmd_clamp[39];
      cmd_mag_r <= cmd_abs[22:0];
    end
    if (state_r == ST_DUTY && div_done) begin
      if (wheel_r) lduty_r <= duty_val;
      else         rduty_r <= duty_val;
    end
    if (state_r == ST_OUT && out_free) begin
      out_rduty_r  <= rduty_r;
      out_lduty_r  <= lduty_r;
      out_rspeed_r <= rspeed_r;
      out_lspeed_r <= lspeed_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_right_duty  = out_rduty_r;
  assign out_left_duty   = out_lduty_r;
  assign out_right_speed = out_rspeed_r;
  assign out_left_speed  = out_lspeed_r;

endmodule

// ===== src/dwpi_checker.sv =====
// port-level checks for the dual wheel pi speed controller, bound to the top level
module dwpi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_right_duty,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // a tick holds the input side until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepted beat");

  // no result appears the cycle after a tick is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result too soon after input beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_right_duty)))
    else $error("stalled output beat changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind dual_wheel_pi_speed_controller dwpi_checker u_dwpi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_right_duty (out_right_duty),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
